// ----- rtl/audio_linear_resampler_unit_macros.svh -----
// Assertion macros used by the resampler checker.
`ifndef AUDIO_LINEAR_RESAMPLER_UNIT_MACROS_SVH
`define AUDIO_LINEAR_RESAMPLER_UNIT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define ALR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ALR_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/alr_pkg.sv -----
// Shared types and constants of the linear resampler.
package alr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int STEP_W      = 21;
   localparam int COUNT_W     = 21;
   localparam int POS_W       = 41;
   localparam int IDX_W       = 17;
   localparam int KEY_W       = 16;
   localparam int FRAC_W      = 16;
   localparam int MAX_RESULTS = 32;
   localparam int RES_W       = 6;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = 2;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 21;
   localparam int DIFF_W      = SAMPLE_W + 1;
   localparam int PROD_W      = 2 * DIFF_W;

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_STEP  = 2'd0,
      CSR_COUNT = 2'd1,
      CSR_MODE  = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [STEP_W-1:0]  step;
      logic [COUNT_W-1:0] count;
      logic               nearest;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] s0;
      logic signed [SAMPLE_W-1:0] s1;
      logic [KEY_W-1:0]           k;
      logic                       interval;
      logic                       last;
   } cmd_type;

   typedef enum logic {
      BK_IVL,
      BK_FINAL
   } bk_state_type;

endpackage

// ----- rtl/audio_linear_resampler_unit.sv -----
// Top level of the linear interpolating sample-rate converter.
//
// req_*: one signed 16-bit sample per beat, tlast on the final sample of a buffer.
// rsp_*: resampled 16-bit samples; tlast closes the results of one input beat,
//        tuser marks the final output of the buffer.
// csr_*: write-only registers (0 step in Q16, 1 output count, 2 nearest mode),
//        written between buffers.
// A beat's results pass through the command queue, blend stage and output register.
// Throughput: one input beat per cycle while the four-entry command queue has room;
// the output engine gives one result per cycle while the receiver does not stall it.
// Beyond 32 outputs in one interval the extra positions are skipped at one
// per cycle in the output engine.
// Reset clears the registers to step 1.0, count 0, linear mode, and empties the queue
// and the output stages.
// A stalled receiver holds the output beat; the queue fills and req_tready falls only
// once four commands wait.
module audio_linear_resampler_unit import alr_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic signed [SAMPLE_W-1:0]   req_tdata,   // [15:0] in_sample
   input  logic                         req_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic signed [SAMPLE_W-1:0]   rsp_tdata,   // [15:0] out_sample
   output logic                         rsp_tlast,
   output logic                         rsp_tuser,   // [0] buffer_end
   input  logic                         csr_we,
   input  logic [CSR_ADDR_W-1:0]        csr_addr,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   logic    q_full, q_empty, q_push, q_pop;
   cmd_type q_cmd, q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_STEP:  cfg_in.step    = csr_wdata[STEP_W-1:0];
            CSR_COUNT: cfg_in.count   = csr_wdata[COUNT_W-1:0];
            CSR_MODE:  cfg_in.nearest = csr_wdata[0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step    <= STEP_RESET;
         cfg_ff.count   <= '0;
         cfg_ff.nearest <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   alr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   alr_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   alr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd_valid  (!q_empty),
      .cmd        (q_head),
      .cmd_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- rtl/alr_front.sv -----
// Input side: takes sample beats, tracks the interval and queues work for the back end.
module alr_front import alr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic signed [SAMPLE_W-1:0] req_tdata,   // [15:0] in_sample
   input  logic                       req_tlast,
   input  logic                       q_full,
   output logic                       q_push,
   output cmd_type                    q_cmd
);

   logic [IDX_W-1:0]           k_ff, k_in;
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic                       have_ff, have_in;
   logic                       accept;
   logic                       over;
   logic                       interval;
   logic signed [SAMPLE_W-1:0] x;

   assign req_tready = !q_full;

   always_comb begin
      accept   = req_tvalid && req_tready;
      over     = k_ff[IDX_W-1];
      x        = over ? prev_ff : req_tdata;
      interval = !over && have_ff;
      q_cmd.s0       = prev_ff;
      q_cmd.s1       = x;
      q_cmd.k        = k_ff[KEY_W-1:0];
      q_cmd.interval = interval;
      q_cmd.last     = req_tlast;
      q_push   = accept && (interval || req_tlast);
      k_in     = k_ff;
      prev_in  = prev_ff;
      have_in  = have_ff;
      if (accept) begin
         if (req_tlast) begin
            k_in    = '0;
            prev_in = '0;
            have_in = 1'b0;
         end else if (!over) begin
            k_in    = k_ff + IDX_W'(1);
            prev_in = x;
            have_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= '0;
         prev_ff <= '0;
         have_ff <= 1'b0;
      end else begin
         k_ff    <= k_in;
         prev_ff <= prev_in;
         have_ff <= have_in;
      end
   end

endmodule

// ----- rtl/alr_cmd_fifo.sv -----
// Short command queue between the front and back ends.
module alr_cmd_fifo import alr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   cmd_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW:0]   wr_ff, wr_in;
   logic [FIFO_AW:0]   rd_ff, rd_in;

   always_comb begin
      empty = (wr_ff == rd_ff);
      full  = (wr_ff[FIFO_AW] != rd_ff[FIFO_AW]) &&
              (wr_ff[FIFO_AW-1:0] == rd_ff[FIFO_AW-1:0]);
      head  = mem_ff[rd_ff[FIFO_AW-1:0]];
      wr_in = (push && !full) ? wr_ff + (FIFO_AW+1)'(1) : wr_ff;
      rd_in = (pop && !empty) ? rd_ff + (FIFO_AW+1)'(1) : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ff[FIFO_AW-1:0]] <= push_cmd;
      end
   end

endmodule

// ----- rtl/alr_back.sv -----
// Output side: walks output positions per command, blends and drives result beats.
module alr_back import alr_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       cmd_valid,
   input  cmd_type                    cmd,
   output logic                       cmd_pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic signed [SAMPLE_W-1:0] rsp_tdata,   // [15:0] out_sample
   output logic                       rsp_tlast,
   output logic                       rsp_tuser    // [0] buffer_end
);

   bk_state_type               state_ff, state_in;
   logic [COUNT_W-1:0]         oi_ff, oi_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [RES_W-1:0]           n_ff, n_in;

   logic                       in_ivl;
   logic [POS_W-1:0]           lim;
   logic                       oi_lt, pos_lt, cap;
   logic [POS_W:0]             pos_sum;
   logic [POS_W-1:0]           pos_adv;
   logic [COUNT_W:0]           oi_inc;
   logic                       nxt_oi_lt, nxt_pos_lt, nxt_cap, nxt_emit;
   logic                       run_end, buf_end, drop_pending;
   logic                       want_emit, emit, drop, finish, go_final;

   logic signed [SAMPLE_W-1:0] base;
   logic signed [DIFF_W-1:0]   diff;
   logic signed [DIFF_W-1:0]   frac;
   logic signed [PROD_W-1:0]   prod;

   logic                       s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_W-1:0] s1_base_ff;
   logic signed [PROD_W-1:0]   s1_prod_ff;
   logic                       s1_run_end_ff, s1_buf_end_ff;
   logic                       out_valid_ff, out_valid_in;
   logic signed [SAMPLE_W-1:0] out_data_ff;
   logic                       out_last_ff, out_user_ff;
   logic                       out_ready, s1_ready;

   logic signed [PROD_W-1:0]   acc;
   logic                       bump;
   logic signed [SAMPLE_W-1:0] blend;

   always_comb begin
      out_ready  = !out_valid_ff || rsp_tready;
      s1_ready   = !s1_valid_ff || out_ready;

      in_ivl     = (state_ff == BK_IVL) && cmd.interval;
      lim        = POS_W'({cmd.k, {FRAC_W{1'b0}}});
      oi_lt      = oi_ff < cfg.count;
      pos_lt     = pos_ff < lim;
      cap        = (n_ff == RES_W'(MAX_RESULTS));
      pos_sum    = {1'b0, pos_ff} + (POS_W+1)'(cfg.step);
      pos_adv    = pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
      oi_inc     = {1'b0, oi_ff} + (COUNT_W+1)'(1);
      nxt_oi_lt  = oi_inc < {1'b0, cfg.count};
      nxt_pos_lt = pos_adv < lim;
      nxt_cap    = (n_ff == RES_W'(MAX_RESULTS - 1));
      buf_end    = (oi_inc == {1'b0, cfg.count});
      nxt_emit   = !nxt_cap && nxt_oi_lt && (!in_ivl || nxt_pos_lt || cmd.last);
      run_end    = !nxt_emit;
      drop_pending = in_ivl && !cmd.last && nxt_oi_lt && nxt_pos_lt;

      want_emit  = cmd_valid && oi_lt && !cap && (!in_ivl || pos_lt);
      emit       = want_emit && s1_ready;
      drop       = cmd_valid && in_ivl && oi_lt && pos_lt && cap && !cmd.last;

      finish     = 1'b0;
      go_final   = 1'b0;
      if (emit) begin
         if (run_end && !drop_pending) begin
            finish = 1'b1;
         end else if (in_ivl && !(nxt_oi_lt && nxt_pos_lt)) begin
            go_final = 1'b1;
         end
      end else if (cmd_valid && !want_emit && !drop) begin
         if (in_ivl && cmd.last && !(oi_lt && pos_lt)) begin
            go_final = 1'b1;
         end else begin
            finish = 1'b1;
         end
      end
      cmd_pop = finish;
   end

   always_comb begin
      state_in = state_ff;
      priority if (finish) begin
         state_in = BK_IVL;
      end else if (go_final) begin
         state_in = BK_FINAL;
      end else begin
         state_in = state_ff;
      end
   end

   always_comb begin
      oi_in  = oi_ff;
      pos_in = pos_ff;
      n_in   = n_ff;
      if (emit || drop) begin
         oi_in  = oi_inc[COUNT_W-1:0];
         pos_in = pos_adv;
      end
      if (emit) begin
         n_in = n_ff + RES_W'(1);
      end
      if (finish) begin
         n_in = '0;
         if (cmd.last) begin
            oi_in  = '0;
            pos_in = '0;
         end
      end
   end

   always_comb begin
      frac = {1'b0, pos_ff[FRAC_W-1:0]};
      if (in_ivl && !cfg.nearest) begin
         base = cmd.s0;
         diff = {cmd.s1[SAMPLE_W-1], cmd.s1} - {cmd.s0[SAMPLE_W-1], cmd.s0};
      end else if (in_ivl) begin
         base = cmd.s0;
         diff = '0;
      end else begin
         base = cmd.s1;
         diff = '0;
      end
      prod = diff * frac;
   end

   always_comb begin
      acc   = {{(PROD_W-SAMPLE_W-FRAC_W){s1_base_ff[SAMPLE_W-1]}}, s1_base_ff,
               {FRAC_W{1'b0}}} + s1_prod_ff;
      bump  = acc[PROD_W-1] && (acc[FRAC_W-1:0] != '0);
      blend = acc[FRAC_W+SAMPLE_W-1:FRAC_W] + {{(SAMPLE_W-1){1'b0}}, bump};
      s1_valid_in  = s1_ready ? emit : s1_valid_ff;
      out_valid_in = out_ready ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IVL;
         oi_ff        <= '0;
         pos_ff       <= '0;
         n_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oi_ff        <= oi_in;
         pos_ff       <= pos_in;
         n_ff         <= n_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         s1_base_ff    <= base;
         s1_prod_ff    <= prod;
         s1_run_end_ff <= run_end;
         s1_buf_end_ff <= buf_end;
      end
      if (out_ready && s1_valid_ff) begin
         out_data_ff <= blend;
         out_last_ff <= s1_run_end_ff;
         out_user_ff <= s1_buf_end_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

// ----- rtl/alr_checker.sv -----
// Port-level checks of the resampler, bound to the top level.
`include "audio_linear_resampler_unit_macros.svh"

module alr_checker import alr_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic signed [SAMPLE_W-1:0] rsp_tdata,
   input logic                       rsp_tlast,
   input logic                       rsp_tuser
);

   `ALR_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "stalled result beat changed")
   `ALR_ASSERT(a_buf_end_closes_run, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tlast, "buffer end without run end")
   `ALR_ASSERT_RST(a_reset_rsp_idle, clock, reset |=> !rsp_tvalid, "result valid after reset")
   `ALR_ASSERT_RST(a_reset_req_ready, clock, reset |=> req_tready, "input not ready after reset")

endmodule

bind audio_linear_resampler_unit alr_checker u_alr_checker (.*);

// ----- tb/sv/audio_linear_resampler_unit_test.sv -----
// Self-checking linear resampler testbench: directed table, long and random buffers, large count.
`timescale 1ns / 100ps

module audio_linear_resampler_unit_test;
   import alr_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = 2'd3;
   localparam int unsigned SAMPLE_CAP   = 65536;
   localparam int unsigned RANDOM_BEATS = 320;
   localparam int unsigned DRAIN_CYCLES = 64;
   localparam int unsigned STALL_LIMIT  = 20000;
   localparam longint unsigned POS_TOP  = (64'd1 << POS_W) - 1;
   localparam longint unsigned IDX_MASK = (64'd1 << COUNT_W) - 1;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] smp;
      logic                       run_end;
      logic                       buffer_end;
   } out_beat_t;

   typedef struct {
      bit                         is_reg;
      logic [CSR_ADDR_W-1:0]      addr;
      int unsigned                value;
      logic signed [SAMPLE_W-1:0] smp;
      bit                         last;
      bit                         typed;
      bit                         has_out;
      out_beat_t                  typed_out;
   } stim_row_t;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic signed [SAMPLE_W-1:0]   req_tdata = '0;
   logic                         req_tlast = 1'b0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic signed [SAMPLE_W-1:0]   rsp_tdata;
   logic                         rsp_tlast;
   logic                         rsp_tuser;
   logic                         csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]        csr_addr = '0;
   logic [CSR_DATA_W-1:0]        csr_wdata = '0;

   // predictor copy of registers and state
   logic [STEP_W-1:0]            step_reg = STEP_RESET;
   logic [COUNT_W-1:0]           count_reg = '0;
   logic                         nearest_reg = 1'b0;
   logic signed [SAMPLE_W-1:0]   held_sample = '0;
   bit                           held_valid = 1'b0;
   longint unsigned              samples_in = 0;
   longint unsigned              outputs_done = 0;
   longint unsigned              out_pos = 0;

   out_beat_t                    due_outputs[$];
   stim_row_t                    stim_rows[$];
   int unsigned                  mismatches = 0;
   int unsigned                  results_seen = 0;
   int unsigned                  quiet_cycles = 0;
   int unsigned                  src_calm = 0;
   int unsigned                  sink_calm = 0;
   bit                           beats_since_idle = 1'b0;

   audio_linear_resampler_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit gap_roll(inout int unsigned calm);
      if (calm > 0) begin
         calm--;
         return 1'b0;
      end
      if ($urandom_range(0, 299) == 0) begin
         calm = 400;
         return 1'b0;
      end
      return $urandom_range(0, 99) < 25;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 15))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return '0;
         3: return '1;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic longint unsigned clamp_pos(input longint unsigned p);
      return (p > POS_TOP) ? POS_TOP : p;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] interpolate(
      input logic signed [SAMPLE_W-1:0] s0, s1, input longint unsigned frac);
      longint acc;
      if (nearest_reg) return s0;
      acc = longint'(s0) * (65536 - longint'(frac)) + longint'(s1) * longint'(frac);
      return SAMPLE_W'(acc / 65536);
   endfunction

   function automatic out_beat_t advance_output(input logic signed [SAMPLE_W-1:0] v);
      out_beat_t r;
      r.smp = v;
      r.run_end = 1'b0;
      r.buffer_end = (outputs_done + 1 == count_reg);
      outputs_done = (outputs_done + 1) & IDX_MASK;
      out_pos = clamp_pos(out_pos + step_reg);
      return r;
   endfunction

   task automatic resample_beat(input logic signed [SAMPLE_W-1:0] smp, input bit last,
                                output out_beat_t made[$]);
      logic signed [SAMPLE_W-1:0] x;
      longint unsigned k, lim, skip, need;
      bit ivl;
      made = {};
      x = smp;
      k = samples_in;
      if (k >= SAMPLE_CAP) begin
         if (!last) return;
         x = held_sample;
         ivl = 1'b0;
      end else begin
         ivl = held_valid;
      end
      if (ivl) begin
         lim = k << FRAC_W;
         while (made.size() < MAX_RESULTS && outputs_done < count_reg && out_pos < lim)
            made.push_back(advance_output(interpolate(held_sample, x, out_pos & 16'hFFFF)));
         // drop what does not fit in one run
         if (outputs_done < count_reg && out_pos < lim) begin
            skip = count_reg - outputs_done;
            if (step_reg != 0) begin
               need = (lim - out_pos + step_reg - 1) / step_reg;
               if (need < skip) skip = need;
            end
            outputs_done = (outputs_done + skip) & IDX_MASK;
            out_pos = clamp_pos(out_pos + skip * step_reg);
         end
      end
      if (last) begin
         while (made.size() < MAX_RESULTS && outputs_done < count_reg)
            made.push_back(advance_output(x));
         held_sample = '0;
         held_valid = 1'b0;
         samples_in = 0;
         outputs_done = 0;
         out_pos = 0;
      end else begin
         held_sample = x;
         held_valid = 1'b1;
         samples_in = k + 1;
      end
      if (made.size() > 0) made[made.size() - 1].run_end = 1'b1;
   endtask

   task automatic flag_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= 100)
         $display("%0t: %s mismatch on result %0d, expected %0d, got %0d",
                  $time, what, results_seen, want, got);
   endtask

   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (due_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      beats_since_idle = 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input int unsigned value);
      if (beats_since_idle) settle_block();
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      case (addr)
         CSR_STEP:  step_reg = value[STEP_W-1:0];
         CSR_COUNT: count_reg = value[COUNT_W-1:0];
         CSR_MODE:  nearest_reg = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_beat(input logic signed [SAMPLE_W-1:0] smp, input bit last,
                            input bit keep_prediction);
      out_beat_t made[$];
      while (gap_roll(src_calm)) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= smp;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      beats_since_idle = 1'b1;
      resample_beat(smp, last, made);
      if (keep_prediction)
         foreach (made[j]) due_outputs.push_back(made[j]);
   endtask

   function automatic stim_row_t reg_row(input logic [CSR_ADDR_W-1:0] addr,
                                         input int unsigned value);
      stim_row_t row;
      row.is_reg = 1'b1;
      row.addr = addr;
      row.value = value;
      return row;
   endfunction

   function automatic stim_row_t beat_row(input logic signed [SAMPLE_W-1:0] smp,
                                          input bit last);
      stim_row_t row;
      row.is_reg = 1'b0;
      row.smp = smp;
      row.last = last;
      row.typed = 1'b0;
      row.has_out = 1'b0;
      return row;
   endfunction

   function automatic stim_row_t typed_row(input logic signed [SAMPLE_W-1:0] smp,
                                           input bit last, input bit has_out,
                                           input out_beat_t typed_out);
      stim_row_t row;
      row = beat_row(smp, last);
      row.typed = 1'b1;
      row.has_out = has_out;
      row.typed_out = typed_out;
      return row;
   endfunction

   always @(posedge clock) rsp_tready <= !gap_roll(sink_calm);

   always @(posedge clock) begin
      out_beat_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_outputs.size() == 0) begin
            flag_mismatch("unexpected result", 0, rsp_tdata);
         end else begin
            want = due_outputs.pop_front();
            if (rsp_tdata !== want.smp) flag_mismatch("out_sample", want.smp, rsp_tdata);
            if (rsp_tlast !== want.run_end) flag_mismatch("run_end", want.run_end, rsp_tlast);
            if (rsp_tuser !== want.buffer_end)
               flag_mismatch("buffer_end", want.buffer_end, rsp_tuser);
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned random_beats, len, cnt;
      random_beats = 0;

      // after reset: count 0, no output at all
      stim_rows.push_back(typed_row(16'sh7FFF, 1'b0, 1'b0, '0));
      stim_rows.push_back(typed_row(16'sh8000, 1'b1, 1'b0, '0));
      // unit step: outputs track the input samples
      stim_rows.push_back(reg_row(CSR_COUNT, 3));
      stim_rows.push_back(typed_row(16'sh7FFF, 1'b0, 1'b0, '0));
      stim_rows.push_back(typed_row(16'sh8000, 1'b0, 1'b1, '{16'sh7FFF, 1'b1, 1'b0}));
      stim_rows.push_back(beat_row(16'sh0000, 1'b1));
      // write to the unused index must leave every register alone
      stim_rows.push_back(reg_row(CSR_SPARE, 21'h1FFFFF));
      stim_rows.push_back(typed_row(16'sd1000, 1'b0, 1'b0, '0));
      stim_rows.push_back(typed_row(-16'sd1000, 1'b0, 1'b1, '{16'sd1000, 1'b1, 1'b0}));
      stim_rows.push_back(beat_row(16'sd7, 1'b1));
      // nearest, half step
      stim_rows.push_back(reg_row(CSR_MODE, 1));
      stim_rows.push_back(reg_row(CSR_STEP, 32768));
      stim_rows.push_back(reg_row(CSR_COUNT, 5));
      stim_rows.push_back(beat_row(16'sd100, 1'b0));
      stim_rows.push_back(beat_row(16'sh8000, 1'b0));
      stim_rows.push_back(beat_row(16'sh7FFF, 1'b1));
      // linear, smallest nominal step
      stim_rows.push_back(reg_row(CSR_MODE, 0));
      stim_rows.push_back(reg_row(CSR_STEP, 4096));
      stim_rows.push_back(reg_row(CSR_COUNT, 40));
      stim_rows.push_back(beat_row(16'sh8000, 1'b0));
      stim_rows.push_back(beat_row(16'sh7FFF, 1'b0));
      stim_rows.push_back(beat_row(16'sd12345, 1'b0));
      stim_rows.push_back(beat_row(-16'sd1, 1'b1));
      // zero step: overflow drop, count reached, then last arriving first
      stim_rows.push_back(reg_row(CSR_STEP, 0));
      stim_rows.push_back(typed_row(16'sd5, 1'b0, 1'b0, '0));
      stim_rows.push_back(beat_row(16'sd7, 1'b0));
      stim_rows.push_back(typed_row(16'sd9, 1'b1, 1'b0, '0));
      stim_rows.push_back(beat_row(16'sd1234, 1'b1));
      // widest step: second output clamps to the final sample
      stim_rows.push_back(reg_row(CSR_STEP, 21'h1FFFFF));
      stim_rows.push_back(reg_row(CSR_COUNT, 2));
      stim_rows.push_back(typed_row(16'sd10, 1'b0, 1'b0, '0));
      stim_rows.push_back(beat_row(16'sd20, 1'b1));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[r]) begin
         if (stim_rows[r].is_reg) begin
            write_reg(stim_rows[r].addr, stim_rows[r].value);
         end else begin
            send_beat(stim_rows[r].smp, stim_rows[r].last, !stim_rows[r].typed);
            if (stim_rows[r].typed && stim_rows[r].has_out)
               due_outputs.push_back(stim_rows[r].typed_out);
         end
      end

      // overlong buffer: samples past the cap are ignored, last repeats the held sample
      write_reg(CSR_STEP, 1048576);
      write_reg(CSR_COUNT, 4100);
      write_reg(CSR_MODE, $urandom_range(0, 1));
      for (int i = 0; i < SAMPLE_CAP + 3; i++) send_beat(random_sample(), 1'b0, 1'b1);
      send_beat(random_sample(), 1'b1, 1'b1);

      while (random_beats < RANDOM_BEATS) begin
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
               0: write_reg(CSR_STEP, 4096);
               1: write_reg(CSR_STEP, 1048576);
               2: write_reg(CSR_STEP, 65536);
               3: write_reg(CSR_STEP, 0);
               4, 5, 6: write_reg(CSR_STEP, $urandom_range(4096, 65535));
               default: write_reg(CSR_STEP, $urandom_range(65536, 1048576));
            endcase
         end
         if ($urandom_range(0, 3) == 0) write_reg(CSR_MODE, $urandom_range(0, 1));
         len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
         if (step_reg == 0 || $urandom_range(0, 7) == 0)
            cnt = $urandom_range(0, 48);
         else
            cnt = (len * 65536) / step_reg + $urandom_range(0, 3);
         write_reg(CSR_COUNT, cnt);
         for (int i = 0; i < len; i++) send_beat(random_sample(), i == len - 1, 1'b1);
         random_beats += len;
      end

      // count 2^20: the final beat emits a full run and drops the rest
      write_reg(CSR_STEP, 1048576);
      write_reg(CSR_COUNT, 1048576);
      send_beat(16'sd1, 1'b0, 1'b1);
      send_beat(16'sd2, 1'b0, 1'b1);
      send_beat(16'sd3, 1'b1, 1'b1);

      settle_block();
      if (mismatches == 0 && due_outputs.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- audio_linear_resampler_unit.f -----
+incdir+rtl
rtl/alr_pkg.sv
rtl/alr_front.sv
rtl/alr_cmd_fifo.sv
rtl/alr_back.sv
rtl/audio_linear_resampler_unit.sv
rtl/alr_checker.sv
tb/sv/audio_linear_resampler_unit_test.sv
